// ===== hw/rtl/stsc_pkg.sv =====
// shared types and constants of the subarray target sum counter
package stsc_pkg;

  localparam int KEY_W      = 28;
  localparam int TARGET_W   = 29;
  localparam int TOTAL_W    = 24;
  localparam int OCC_W      = 13;
  localparam int HASH_STEPS = 7;
  localparam int HASH_BPS   = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [OCC_W-1:0]   OCC_MAX   = {OCC_W{1'b1}};

  // register byte offset bit that selects the register
  localparam logic REG_TARGET_SUM = 1'b0;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_LHASH,
    S_LRD,
    S_LCHK,
    S_UHASH,
    S_URD,
    S_UCHK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [OCC_W-1:0] occ;
  } entry_t;

  typedef struct packed {
    logic load_item;
    logic hash_start;
    logic hash_sel_want;
    logic hash_step;
    logic probe_init;
    logic mem_rd;
    logic probe_next;
    logic add_total;
    logic wr_inc;
    logic wr_new;
    logic set_ovf;
    logic out_load;
    logic state_clear;
    logic clr_start;
    logic clr_step;
  } stsc_cmd_t;

  typedef struct packed {
    logic want_ok;
    logic hash_done;
    logic rd_vld;
    logic rd_match;
    logic probe_last;
    logic clr_done;
    logic out_free;
    logic last;
  } stsc_sts_t;

endpackage

// ===== hw/rtl/stsc_ctrl.sv =====
// controller state machine: sequences hashing, probing, table update and clearing
module stsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  stsc_pkg::stsc_sts_t sts,
  output stsc_pkg::stsc_cmd_t cmd
);
  import stsc_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_PREP;
      S_PREP:  state_nxt = sts.want_ok ? S_LHASH : S_UHASH;
      S_LHASH: if (sts.hash_done) state_nxt = S_LRD;
      S_LRD:   state_nxt = S_LCHK;
      S_LCHK: begin
        if (!sts.rd_vld || sts.rd_match || sts.probe_last) state_nxt = S_UHASH;
        else state_nxt = S_LRD;
      end
      S_UHASH: if (sts.hash_done) state_nxt = S_URD;
      S_URD:   state_nxt = S_UCHK;
      S_UCHK: begin
        if (!sts.rd_vld || sts.rd_match || sts.probe_last) state_nxt = S_OUT;
        else state_nxt = S_URD;
      end
      S_OUT: begin
        if (sts.out_free) state_nxt = sts.last ? S_CLEAR : S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE:  cmd.load_item = in_valid;
      S_PREP: begin
        cmd.hash_start    = 1'b1;
        cmd.hash_sel_want = sts.want_ok;
      end
      S_LHASH, S_UHASH: begin
        cmd.hash_step  = !sts.hash_done;
        cmd.probe_init = sts.hash_done;
      end
      S_LRD, S_URD: cmd.mem_rd = 1'b1;
      S_LCHK: begin
        if (!sts.rd_vld || sts.rd_match || sts.probe_last) begin
          cmd.add_total  = sts.rd_vld && sts.rd_match;
          cmd.hash_start = 1'b1;
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      S_UCHK: begin
        if (!sts.rd_vld) cmd.wr_new = 1'b1;
        else if (sts.rd_match) cmd.wr_inc = 1'b1;
        else if (sts.probe_last) cmd.set_ovf = 1'b1;
        else cmd.probe_next = 1'b1;
      end
      S_OUT: begin
        cmd.out_load    = sts.out_free;
        cmd.state_clear = sts.out_free && sts.last;
        cmd.clr_start   = sts.out_free && sts.last;
      end
      default: cmd = '0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  // checks
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_PREP))
    else $error("accepted item did not start processing");
  a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR && !sts.clr_done) |=> (state_r == S_CLEAR))
    else $error("clearing pass left early");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending item");
endmodule

// ===== hw/rtl/stsc_dp.sv =====
// datapath: prefix sum, hash remainder unit, table memory, totals and result register
module stsc_dp #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int ELEMENT_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [ELEMENT_BITS-1:0]      elem,
  input  logic                                is_last,
  input  logic signed [stsc_pkg::TARGET_W-1:0] target,
  input  logic                                out_stall,
  input  stsc_pkg::stsc_cmd_t                 cmd,
  output stsc_pkg::stsc_sts_t                 sts,
  output logic                                out_valid,
  output logic [stsc_pkg::TOTAL_W-1:0]        out_total,
  output logic                                out_final,
  output logic                                out_ovf
);
  import stsc_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = SLOT_W + 1;
  localparam logic [CNT_W-1:0]  N_C    = CNT_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0]  N_M1   = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [SLOT_W-1:0] SLOT_M = SLOT_W'(TABLE_ENTRIES - 1);

  logic [KEY_W-1:0]   prefix_r, key_r, mkey_r;
  logic               last_r, ovf_r, out_valid_r, out_final_r, out_ovf_r;
  logic [TOTAL_W-1:0] total_r, out_total_r;
  logic [SLOT_W-1:0]  rem_r, addr_r, clr_r;
  logic [2:0]         hstep_r;
  logic [CNT_W-1:0]   pcnt_r;
  entry_t             rdata_r;
  entry_t             mem [TABLE_ENTRIES];

  logic signed [32:0] elem_wide;
  logic signed [29:0] want;
  logic [KEY_W-1:0]   prefix_nxt;
  logic [CNT_W-1:0]   rem_nxt;
  logic [TOTAL_W:0]   total_sum;
  logic [OCC_W-1:0]   occ_inc;
  logic               we;
  logic [SLOT_W-1:0]  waddr;
  entry_t             wdata;

  // prefix advance and lookup key
  assign elem_wide  = 33'(elem);
  assign prefix_nxt = prefix_r + elem_wide[KEY_W-1:0];
  assign want       = 30'(signed'(prefix_r)) - 30'(target);

  // four key bits per step, home slot = key mod table size
  always_comb begin
    rem_nxt = {1'b0, rem_r};
    for (int i = 0; i < HASH_BPS; i++) begin
      rem_nxt = {rem_nxt[SLOT_W-1:0], mkey_r[KEY_W-1-i]};
      if (rem_nxt >= N_C) rem_nxt = rem_nxt - N_C;
    end
  end

  // saturating arithmetic
  assign total_sum = {1'b0, total_r} + (TOTAL_W+1)'(rdata_r.occ);
  assign occ_inc   = (rdata_r.occ == OCC_MAX) ? OCC_MAX : rdata_r.occ + 1'b1;

  // table write port
  always_comb begin
    we    = 1'b0;
    waddr = addr_r;
    wdata = '0;
    if (cmd.clr_step) begin
      we        = 1'b1;
      waddr     = clr_r;
      wdata.vld = (clr_r == '0);
      wdata.occ = (clr_r == '0) ? OCC_W'(1) : '0;
    end else if (cmd.wr_new) begin
      we    = 1'b1;
      wdata = '{vld: 1'b1, key: key_r, occ: OCC_W'(1)};
    end else if (cmd.wr_inc) begin
      we    = 1'b1;
      wdata = '{vld: 1'b1, key: key_r, occ: occ_inc};
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.mem_rd) rdata_r <= mem[addr_r];
  end

  // payload registers: last flag, key, hash, probe and result
  always_ff @(posedge clk) begin
    if (cmd.load_item) last_r <= is_last;
    if (cmd.hash_start) begin
      key_r   <= cmd.hash_sel_want ? want[KEY_W-1:0] : prefix_r;
      mkey_r  <= cmd.hash_sel_want ? want[KEY_W-1:0] : prefix_r;
      rem_r   <= '0;
      hstep_r <= '0;
    end else if (cmd.hash_step) begin
      mkey_r  <= mkey_r << HASH_BPS;
      rem_r   <= rem_nxt[SLOT_W-1:0];
      hstep_r <= hstep_r + 3'd1;
    end
    if (cmd.probe_init) begin
      addr_r <= rem_r;
      pcnt_r <= '0;
    end else if (cmd.probe_next) begin
      addr_r <= (addr_r == SLOT_M) ? '0 : addr_r + 1'b1;
      pcnt_r <= pcnt_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_total_r <= total_r;
      out_final_r <= last_r;
      out_ovf_r   <= ovf_r;
    end
  end

  // control state: running sums, flags, clear sweep, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r    <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.state_clear) begin
        prefix_r <= '0;
        total_r  <= '0;
        ovf_r    <= 1'b0;
      end else begin
        if (cmd.load_item) prefix_r <= prefix_nxt;
        if (cmd.add_total) begin
          total_r <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        end
        if (cmd.set_ovf) ovf_r <= 1'b1;
      end
      if (cmd.clr_start) clr_r <= '0;
      else if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // status to the controller
  assign sts.want_ok    = (want[29:27] == 3'b000) || (want[29:27] == 3'b111);
  assign sts.hash_done  = (hstep_r == 3'(HASH_STEPS));
  assign sts.rd_vld     = rdata_r.vld;
  assign sts.rd_match   = (rdata_r.key == key_r);
  assign sts.probe_last = (pcnt_r == N_M1);
  assign sts.clr_done   = (clr_r == SLOT_M);
  assign sts.out_free   = !out_valid_r || !out_stall;
  assign sts.last       = last_r;

  assign out_valid = out_valid_r;
  assign out_total = out_total_r;
  assign out_final = out_final_r;
  assign out_ovf   = out_ovf_r;

  // checks
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && last_r) |=> (prefix_r == '0 && total_r == '0 && !ovf_r))
    else $error("state not cleared after last item");
endmodule

// ===== hw/rtl/subarray_target_sum_counter.sv =====
// top level: configuration register, controller and datapath
// Counts contiguous subarrays whose sum equals target_sum. One item is taken at a time and
// runs through up to two linear-probe searches (lookup of prefix - target, skipped when that
// key is out of range, then update of prefix): each hashes its key in the remainder unit and
// then reads and checks one slot per probe on the table memory. After reset and after every
// item marked last, the table is swept clear, during which no item is taken; configuration is
// still accepted.
module subarray_target_sum_counter #(
  parameter int TABLE_ENTRIES = 4096,
  parameter int ELEMENT_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [ELEMENT_BITS-1:0] in_element_value,
  input  logic                           in_is_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [23:0]                    out_match_total,
  output logic                           out_final_result,
  output logic                           out_table_overflow,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import stsc_pkg::*;

  logic signed [TARGET_W-1:0] target_r;
  stsc_cmd_t cmd;
  stsc_sts_t sts;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_TARGET_SUM) begin
      target_r <= pwdata[TARGET_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TARGET_SUM) ? 32'(target_r) : '0;

  stsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  stsc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .ELEMENT_BITS  (ELEMENT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .elem      (in_element_value),
    .is_last   (in_is_last),
    .target    (target_r),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_total (out_match_total),
    .out_final (out_final_result),
    .out_ovf   (out_table_overflow)
  );
endmodule

// ===== tb/tb_top.sv =====
// testbench for the subarray target sum counter: driver, monitor and scoreboard
`timescale 1ns / 1ps

module tb_top;
  import stsc_pkg::*;

  localparam int TBL_SLOTS   = 4096;
  localparam int IDLE_LIMIT  = 200000;
  localparam int SETTLE_CYC  = 60;
  localparam int LONG_HOLD   = 400;
  localparam longint KEY_MIN = -(64'sd1 <<< (KEY_W - 1));
  localparam longint KEY_MAX = (64'sd1 <<< (KEY_W - 1)) - 1;
  localparam int TARGET_MIN  = -(1 << (TARGET_W - 1));
  localparam int TARGET_MAX  = (1 << (TARGET_W - 1)) - 1;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } elem_item_t;

  typedef struct {
    logic [TOTAL_W-1:0] total;
    logic               fin;
    logic               ovf;
  } count_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_element_value = '0;
  logic in_is_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [23:0] out_match_total;
  logic out_final_result;
  logic out_table_overflow;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  subarray_target_sum_counter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_element_value(in_element_value), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_match_total(out_match_total), .out_final_result(out_final_result),
    .out_table_overflow(out_table_overflow),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state: prefix sum, running total and prefix occurrence counts
  logic signed [KEY_W-1:0]    prefix_acc = '0;
  logic [TOTAL_W-1:0]         total_acc = '0;
  logic                       table_full_seen = 1'b0;
  logic signed [TARGET_W-1:0] target_reg = '0;
  int                         prefix_occ[longint];

  elem_item_t    pending_elems[$];
  count_result_t expected_counts[$];
  int            error_count = 0;
  bit            send_hold = 1'b0;
  bit            long_hold_req = 1'b0;

  function automatic void clear_counts();
    prefix_acc = '0;
    total_acc = '0;
    table_full_seen = 1'b0;
    prefix_occ.delete();
    prefix_occ[0] = 1;
  endfunction

  // advance the counter model by one element and queue the expected result
  function automatic void predict_count(logic signed [15:0] value, logic last);
    longint        want;
    longint        key;
    longint        sum;
    count_result_t res;
    prefix_acc = prefix_acc + KEY_W'(value);
    key = longint'(prefix_acc);
    want = key - longint'(target_reg);
    if (want >= KEY_MIN && want <= KEY_MAX && prefix_occ.exists(want)) begin
      sum = longint'(total_acc) + prefix_occ[want];
      total_acc = (sum > longint'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum);
    end
    if (prefix_occ.exists(key)) begin
      if (prefix_occ[key] < int'(OCC_MAX)) prefix_occ[key] = prefix_occ[key] + 1;
    end else if (prefix_occ.num() < TBL_SLOTS) begin
      prefix_occ[key] = 1;
    end else begin
      table_full_seen = 1'b1;
    end
    res.total = total_acc;
    res.fin = last;
    res.ovf = table_full_seen;
    expected_counts.insert(expected_counts.size(), res);
    if (last) clear_counts();
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, exp);
    error_count++;
  endtask

  // driver: bursts of items with random gaps
  int burst_left = 1;
  int gap_left = 0;
  elem_item_t drive_item;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_count(in_element_value, in_is_last);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pending_elems.size() > 0 && !send_hold) begin
          drive_item = pending_elems.pop_front();
          in_valid <= 1'b1;
          in_element_value <= drive_item.value;
          in_is_last <= drive_item.last;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int phase_cnt = 0;
  always @(posedge clk) begin
    phase_cnt++;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= (phase_cnt % 5 < 2);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // monitor and scoreboard
  count_result_t exp_res;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected result, total %0d", $realtime, out_match_total);
        error_count++;
      end else begin
        exp_res = expected_counts.pop_front();
        if (out_match_total !== exp_res.total)
          report_mismatch("match_total", out_match_total, exp_res.total);
        if (out_final_result !== exp_res.fin)
          report_mismatch("final_result", out_final_result, exp_res.fin);
        if (out_table_overflow !== exp_res.ovf)
          report_mismatch("table_overflow", out_table_overflow, exp_res.ovf);
      end
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_target(int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_TARGET_SUM, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    target_reg = TARGET_W'(value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // wait until every item is sent and every result has come back
  task automatic drain();
    while (pending_elems.size() > 0 || in_valid || expected_counts.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic push_elem(int value, bit last);
    elem_item_t it;
    it.value = 16'(value);
    it.last = last;
    pending_elems.insert(pending_elems.size(), it);
  endtask

  // one array of random length; mostly small values so matches are common
  task automatic push_random_array(ref int sent);
    int len;
    int kind;
    int v;
    len = $urandom_range(1, 40);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < len; i++) begin
      if (kind < 7) v = int'($urandom_range(0, 6)) - 3;
      else if (kind < 9) v = int'($signed(16'($urandom_range(0, 65535))));
      else v = ($urandom_range(0, 1) == 1) ? int'($signed(16'($urandom_range(0, 65535))))
                                             : int'($urandom_range(0, 4)) - 2;
      push_elem(v, i == len - 1);
    end
    sent += len;
  endtask

  int targets[8];
  int sent;

  initial begin
    clear_counts();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes with target zero
    write_target(0);
    push_elem(32767, 0);
    push_elem(-32768, 0);
    push_elem(1, 0);
    push_elem(0, 0);
    push_elem(0, 1);
    push_elem(-1, 1);
    drain();

    // directed: small target with repeats
    write_target(2);
    push_elem(1, 0);
    push_elem(1, 0);
    push_elem(0, 0);
    push_elem(2, 0);
    push_elem(-2, 0);
    push_elem(2, 1);
    drain();

    // directed: lookup keys out of the prefix range at both target extremes
    write_target(TARGET_MAX);
    push_elem(-32768, 0);
    push_elem(-5, 0);
    push_elem(7, 1);
    drain();
    write_target(TARGET_MIN);
    push_elem(32767, 0);
    push_elem(3, 0);
    push_elem(0, 1);
    drain();

    // long receiver hold while the sender keeps offering
    write_target(0);
    long_hold_req = 1'b1;
    for (int i = 0; i < 30; i++) push_elem(int'($urandom_range(0, 2)) - 1, i == 29);
    drain();

    // fast total growth and repeated counts on a run of zeros
    for (int i = 0; i < 120; i++) push_elem(0, i == 119);
    drain();

    // large prefixes on a run of maximal elements
    for (int i = 0; i < 40; i++) push_elem(32767, i == 39);
    drain();

    // random phases over several targets
    targets = '{0, 1, -2, 3, TARGET_MAX, TARGET_MIN, 0, 0};
    targets[6] = int'($urandom_range(0, 8)) - 4;
    targets[7] = int'($signed(29'($urandom)));
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_target(targets[ph]);
      while (sent < (ph + 1) * 105) push_random_array(sent);
      if (ph == 3) begin
        // once the pipeline is empty, the sender pauses, then resumes
        while (expected_counts.size() > 0 || pending_elems.size() > 0) @(posedge clk);
        send_hold = 1'b1;
        repeat (40) @(posedge clk);
        send_hold = 1'b0;
      end
      drain();
    end

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== subarray_target_sum_counter.f =====
hw/rtl/stsc_pkg.sv
hw/rtl/stsc_ctrl.sv
hw/rtl/stsc_dp.sv
hw/rtl/subarray_target_sum_counter.sv
tb/tb_top.sv
